[hdl/mqec_pkg.sv]
package mqec_pkg;

  localparam int NumEncodersDefault = 6;
  localparam int CountWidthDefault  = 16;

  localparam int LanesMax      = 6;
  localparam int PinWidth      = 6;
  localparam int OutCountWidth = 16;
  localparam int HistWidth     = 4;

  localparam int InDataWidth  = 16;
  localparam int OutDataWidth = 104;
  localparam int MaskLsb      = LanesMax * OutCountWidth;

  localparam logic [HistWidth-1:0] PatDownA = 4'h9;
  localparam logic [HistWidth-1:0] PatDownB = 4'h3;
  localparam logic [HistWidth-1:0] PatUpA   = 4'h3;
  localparam logic [HistWidth-1:0] PatUpB   = 4'h9;

  typedef struct packed {
    logic out_valid;
    logic skid_valid;
  } buf_status_t;

endpackage

[hdl/mqec_lane.sv]
module mqec_lane
  import mqec_pkg::*;
#(
  parameter int COUNT_WIDTH = CountWidthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic                   pin_a_i,
  input  logic                   pin_b_i,
  output logic [COUNT_WIDTH-1:0] count_o,
  output logic                   changed_o
);

  logic                   last_a_q, last_b_q;
  logic [HistWidth-1:0]   hist_a_q, hist_a_d;
  logic [HistWidth-1:0]   hist_b_q, hist_b_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic                   changed;

  assign changed  = (pin_a_i != last_a_q) || (pin_b_i != last_b_q);
  assign hist_a_d = changed ? {hist_a_q[HistWidth-2:0], pin_a_i} : hist_a_q;
  assign hist_b_d = changed ? {hist_b_q[HistWidth-2:0], pin_b_i} : hist_b_q;

  always_comb begin
    count_d = count_q;
    if (changed) begin
      if (hist_a_d == PatDownA && hist_b_d == PatDownB) begin
        count_d = count_q - COUNT_WIDTH'(1);
      end else if (hist_a_d == PatUpA && hist_b_d == PatUpB) begin
        count_d = count_q + COUNT_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_a_q <= 1'b0;
      last_b_q <= 1'b0;
      hist_a_q <= '0;
      hist_b_q <= '0;
      count_q  <= '0;
    end else if (accept_i) begin
      last_a_q <= pin_a_i;
      last_b_q <= pin_b_i;
      hist_a_q <= hist_a_d;
      hist_b_q <= hist_b_d;
      count_q  <= count_d;
    end
  end

  assign count_o   = count_d;
  assign changed_o = changed;

endmodule

[hdl/mqec_merge.sv]
module mqec_merge
  import mqec_pkg::*;
#(
  parameter int NUM_ENCODERS = NumEncodersDefault,
  parameter int COUNT_WIDTH  = CountWidthDefault
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     accept_i,
  input  logic [NUM_ENCODERS-1:0][COUNT_WIDTH-1:0] counts_i,
  input  logic [NUM_ENCODERS-1:0]                  changed_i,
  input  logic                                     out_ready_i,
  output logic                                     out_valid_o,
  output logic [OutDataWidth-1:0]                  out_data_o,
  output buf_status_t                              status_o
);

  logic [NUM_ENCODERS-1:0][OutCountWidth-1:0] ext;
  logic [OutDataWidth-1:0] word;
  logic [OutDataWidth-1:0] out_q, skid_q;
  logic                    out_valid_q, skid_valid_q;
  logic                    pop;

  for (genvar i = 0; i < NUM_ENCODERS; i++) begin : g_ext
    if (COUNT_WIDTH >= OutCountWidth) begin : g_trunc
      assign ext[i] = counts_i[i][OutCountWidth-1:0];
    end else begin : g_sext
      assign ext[i] = {{(OutCountWidth-COUNT_WIDTH){counts_i[i][COUNT_WIDTH-1]}},
                       counts_i[i]};
    end
  end

  always_comb begin
    word = '0;
    for (int i = 0; i < NUM_ENCODERS; i++) begin
      word[i*OutCountWidth +: OutCountWidth] = ext[i];
    end
    word[MaskLsb +: NUM_ENCODERS] = changed_i;
  end

  assign pop = out_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (accept_i) begin
      if (out_valid_q && !out_ready_i) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (accept_i) begin
      if (out_valid_q && !out_ready_i) begin
        skid_q <= word;
      end else begin
        out_q <= word;
      end
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_data_o          = out_q;
  assign status_o.out_valid  = out_valid_q;
  assign status_o.skid_valid = skid_valid_q;

endmodule

[hdl/multi_quadrature_encoder_counter_top.sv]
// Quadrature counter for up to six rotary encoders. Each input word is one sample of the A
// and B pins of all encoders; one lane per encoder shifts the pin levels into 4-bit
// histories whenever its pins change and steps its wrapping signed count down or up on a
// full detent pattern. Every input word produces one output word with all counts after
// that sample and a mask of the lanes whose pins changed. The lanes work combinationally
// on the offered sample, and the edge that accepts it also loads the output register, or
// the skid register while the output is stalled; a sample can be taken every cycle while
// the skid register is empty. A two-entry output buffer keeps the input ready for one
// extra word while the output is stalled.
// Counts and histories are zero after reset, and lanes beyond NUM_ENCODERS read as zero.
module multi_quadrature_encoder_counter_top
  import mqec_pkg::*;
#(
  parameter int NUM_ENCODERS = NumEncodersDefault,
  parameter int COUNT_WIDTH  = CountWidthDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // pins_a[5:0], pins_b[11:6], zero fill [15:12]
  input  logic [InDataWidth-1:0]  s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // count_0 .. count_5 in 16-bit slices [95:0], changed_mask[101:96], zero fill [103:102]
  output logic [OutDataWidth-1:0] m_axis_tdata
);

  logic [PinWidth-1:0]                      pins_a, pins_b;
  logic                                     accept;
  logic [NUM_ENCODERS-1:0][COUNT_WIDTH-1:0] counts;
  logic [NUM_ENCODERS-1:0]                  changed;
  buf_status_t                              status;

  assign pins_a = s_axis_tdata[PinWidth-1:0];
  assign pins_b = s_axis_tdata[2*PinWidth-1:PinWidth];
  assign s_axis_tready = !status.skid_valid;
  assign accept = s_axis_tvalid && s_axis_tready;

  for (genvar i = 0; i < NUM_ENCODERS; i++) begin : g_lane
    mqec_lane #(
      .COUNT_WIDTH(COUNT_WIDTH)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .accept_i (accept),
      .pin_a_i  (pins_a[i]),
      .pin_b_i  (pins_b[i]),
      .count_o  (counts[i]),
      .changed_o(changed[i])
    );
  end

  mqec_merge #(
    .NUM_ENCODERS(NUM_ENCODERS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .counts_i   (counts),
    .changed_i  (changed),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_data_o (m_axis_tdata),
    .status_o   (status)
  );

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.skid_valid |-> status.out_valid)
    else $error("skid entry held without a valid output entry");

  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && status.out_valid && !m_axis_tready) |=> status.skid_valid)
    else $error("word accepted during output stall was not buffered");

  a_unused_lanes_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[MaskLsb +: LanesMax] >> NUM_ENCODERS) == '0))
    else $error("changed mask set for an unused lane");

endmodule

[sim/tb_multi_quadrature_encoder_counter_top.sv]
module tb_multi_quadrature_encoder_counter_top;
  import mqec_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ENCODERS = NumEncodersDefault;
  localparam int COUNT_WIDTH  = CountWidthDefault;
  localparam int CycleLimit   = 400000;
  localparam int DrainCycles  = 10;
  localparam int HoldCycles   = 300;
  localparam int MaxReported  = 10;

  // One full detent in the up direction walks this table forward.
  localparam logic [1:0] DetentSeq [4] = '{2'b11, 2'b01, 2'b00, 2'b10};

  typedef struct packed {
    logic [PinWidth-1:0] pins_a;
    logic [PinWidth-1:0] pins_b;
  } pin_sample_t;

  typedef struct packed {
    logic [LanesMax-1:0][OutCountWidth-1:0] counts;
    logic [PinWidth-1:0]                    changed;
  } encoder_report_t;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [InDataWidth-1:0]  s_axis_tdata  = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OutDataWidth-1:0] m_axis_tdata;

  pin_sample_t     sample_q [$];
  encoder_report_t report_q [$];

  // Predictor state.
  logic                   prev_a [LanesMax];
  logic                   prev_b [LanesMax];
  logic [HistWidth-1:0]   hist_a [LanesMax];
  logic [HistWidth-1:0]   hist_b [LanesMax];
  logic [COUNT_WIDTH-1:0] pos    [LanesMax];

  // Stimulus state: current {a, b} levels and walking direction per lane.
  logic [1:0] lane_ab [LanesMax];
  logic       lane_up [LanesMax];

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  int  err_cnt        = 0;
  int  cycle_cnt      = 0;
  int  hold_left      = 0;
  bit  hold_go        = 1'b0;
  bit  hold_seen      = 1'b0;

  multi_quadrature_encoder_counter_top #(
    .NUM_ENCODERS(NUM_ENCODERS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic encoder_report_t track_encoders(input logic [PinWidth-1:0] pa,
                                                     input logic [PinWidth-1:0] pb);
    encoder_report_t  rep;
    logic signed [63:0] wide;
    rep = '0;
    for (int i = 0; i < NUM_ENCODERS; i++) begin
      if (pa[i] != prev_a[i] || pb[i] != prev_b[i]) begin
        rep.changed[i] = 1'b1;
        hist_a[i] = {hist_a[i][HistWidth-2:0], pa[i]};
        hist_b[i] = {hist_b[i][HistWidth-2:0], pb[i]};
        if (hist_a[i] == PatDownA && hist_b[i] == PatDownB) pos[i] = pos[i] - 1'b1;
        if (hist_a[i] == PatUpA && hist_b[i] == PatUpB) pos[i] = pos[i] + 1'b1;
      end
      prev_a[i] = pa[i];
      prev_b[i] = pb[i];
      wide = $signed(pos[i]);
      rep.counts[i] = wide[OutCountWidth-1:0];
    end
    return rep;
  endfunction

  task automatic flag_mismatch(input string what, input longint want, input longint got);
    err_cnt++;
    if (err_cnt <= MaxReported) begin
      $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    end
  endtask

  task automatic check_report(input logic [OutDataWidth-1:0] data);
    encoder_report_t want;
    if (report_q.size() == 0) begin
      flag_mismatch("unexpected output word", 0, data[MaskLsb +: PinWidth]);
    end else begin
      want = report_q.pop_front();
      for (int i = 0; i < LanesMax; i++) begin
        if (data[i*OutCountWidth +: OutCountWidth] != want.counts[i]) begin
          flag_mismatch($sformatf("count_%0d", i), want.counts[i],
                        data[i*OutCountWidth +: OutCountWidth]);
        end
      end
      if (data[MaskLsb +: PinWidth] != want.changed) begin
        flag_mismatch("changed_mask", want.changed, data[MaskLsb +: PinWidth]);
      end
    end
  endtask

  always @(posedge clk_i) begin : drive_samples
    pin_sample_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        report_q.push_back(track_encoders(s_axis_tdata[PinWidth-1:0],
                                          s_axis_tdata[2*PinWidth-1:PinWidth]));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = sample_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= InDataWidth'({nxt.pins_b, nxt.pins_a});
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_report(m_axis_tdata);
      end
      m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_go != hold_seen) begin
      hold_left <= HoldCycles;
      hold_seen <= hold_go;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic queue_sample(input logic [PinWidth-1:0] pa, input logic [PinWidth-1:0] pb);
    pin_sample_t s;
    s.pins_a = pa;
    s.pins_b = pb;
    sample_q.push_back(s);
    for (int i = 0; i < LanesMax; i++) begin
      lane_ab[i] = {pa[i], pb[i]};
    end
  endtask

  function automatic logic [1:0] detent_step(input logic [1:0] ab, input logic up);
    int k;
    k = 0;
    for (int j = 0; j < 4; j++) begin
      if (DetentSeq[j] == ab) k = j;
    end
    return up ? DetentSeq[(k + 1) % 4] : DetentSeq[(k + 3) % 4];
  endfunction

  task automatic rotate_lanes(input logic [LanesMax-1:0] up_mask,
                              input logic [LanesMax-1:0] move_mask);
    logic [PinWidth-1:0] pa;
    logic [PinWidth-1:0] pb;
    logic [1:0]          ab;
    for (int i = 0; i < LanesMax; i++) begin
      ab = move_mask[i] ? detent_step(lane_ab[i], up_mask[i]) : lane_ab[i];
      pa[i] = ab[1];
      pb[i] = ab[0];
    end
    queue_sample(pa, pb);
  endtask

  // Mostly clean rotation with random direction changes, bounces, pauses and glitches.
  task automatic queue_random_sample();
    logic [LanesMax-1:0] up_mask;
    logic [LanesMax-1:0] move_mask;
    logic [PinWidth-1:0] pa;
    logic [PinWidth-1:0] pb;
    logic [LanesMax-1:0] noise_mask;
    int                  r;
    noise_mask = '0;
    for (int i = 0; i < LanesMax; i++) begin
      if ($urandom_range(99) < 3) lane_up[i] = !lane_up[i];
      r = $urandom_range(99);
      up_mask[i]    = (r < 55) ? lane_up[i] : !lane_up[i];
      move_mask[i]  = (r < 65);
      noise_mask[i] = (r >= 85);
    end
    rotate_lanes(up_mask, move_mask);
    if (noise_mask != '0) begin
      void'(sample_q.pop_back());
      pa = $urandom_range(63);
      pb = $urandom_range(63);
      for (int i = 0; i < LanesMax; i++) begin
        if (!noise_mask[i]) begin
          pa[i] = lane_ab[i][1];
          pb[i] = lane_ab[i][0];
        end
      end
      queue_sample(pa, pb);
    end
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int n_items,
                           input bit squeeze);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (n_items) queue_random_sample();
    if (squeeze) hold_go = !hold_go;
    while (sample_q.size() != 0 || s_axis_tvalid || report_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  initial begin
    for (int i = 0; i < LanesMax; i++) begin
      prev_a[i]  = 1'b0;
      prev_b[i]  = 1'b0;
      hist_a[i]  = '0;
      hist_b[i]  = '0;
      pos[i]     = '0;
      lane_ab[i] = 2'b00;
      lane_up[i] = i[0];
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    queue_sample('0, '0);
    queue_sample('1, '1);
    repeat (4) rotate_lanes('0, '1);
    repeat (8) rotate_lanes('1, '1);
    repeat (4) rotate_lanes(6'h15, '1);
    queue_sample(6'h2A, 6'h15);
    queue_sample(6'h15, 6'h2A);
    queue_sample('0, '1);

    run_phase(0, 0, 350, 1'b1);
    run_phase(78, 0, 350, 1'b0);
    run_phase(0, 78, 350, 1'b0);
    run_phase(6, 6, 350, 1'b0);

    repeat (DrainCycles) @(negedge clk_i);
    if (err_cnt == 0 && report_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/mqec_pkg.sv
hdl/mqec_lane.sv
hdl/mqec_merge.sv
hdl/multi_quadrature_encoder_counter_top.sv
sim/tb_multi_quadrature_encoder_counter_top.sv
